@@ rtl/sibd_pkg.sv @@
package sibd_pkg;

    localparam int SYM_W         = 8;
    localparam int SYM_SLOTS     = 16;
    localparam int SYM_IDX_W     = 4;
    localparam int COUNT_W       = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int BITS_PER_STEP = 8;

    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

    typedef logic [SYM_SLOTS-1:0][SYM_W-1:0] t_sym_tab;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_status;

endpackage

@@ rtl/sibd_base_check.sv @@
module sibd_base_check
    import sibd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_sym_tab             i_sym_tab,
    input  logic [COUNT_W-1:0]   i_count,
    output t_chk_status          o_status
);

    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_ok, n_ok;
    logic [IW-1:0] r_idx, n_idx;

    logic             range_bad;
    logic             sym_bad;
    logic             dup;
    logic             at_end;
    logic [SYM_W-1:0] cur;

    assign range_bad = (i_count < COUNT_W'(2)) || (i_count > COUNT_W'(MAX_SYMBOLS));
    assign cur       = i_sym_tab[SYM_IDX_W'(r_idx)];
    assign sym_bad   = (cur == CH_NUL) || (cur == CH_MINUS) || (cur == CH_PLUS);
    assign at_end    = (COUNT_W'(r_idx) == i_count - COUNT_W'(1));

    // compare the current symbol against every later used symbol at once
    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if ((j > int'(r_idx)) && (j < int'(i_count)) &&
                (i_sym_tab[j] == cur)) begin
                dup = 1'b1;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_ok   = r_ok;
        n_idx  = r_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy) begin
            if (range_bad || sym_bad || dup) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b0;
            end else if (at_end) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_ok   = 1'b1;
            end else begin
                n_idx = r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ok   <= n_ok;
            r_idx  <= n_idx;
        end
    end

    assign o_status.done = r_done;
    assign o_status.ok   = r_ok;

endmodule

@@ rtl/sibd_divider.sv @@
module sibd_divider
    import sibd_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DW-1:0]      i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient,
    output logic [COUNT_W-1:0] o_remainder
);

    localparam int STEPS = DW / BITS_PER_STEP;
    localparam int CW    = $clog2(STEPS) + 1;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [DW-1:0]      r_word, n_word;
    logic [COUNT_W-1:0] r_rem, n_rem;

    logic [DW-1:0]      step_word;
    logic [COUNT_W-1:0] step_rem;
    logic [COUNT_W-1:0] trial;
    logic               qbit;

    // long division, one radix-2 step per bit; quotient bits shift in at the bottom
    always_comb begin
        step_word = r_word;
        step_rem  = r_rem;
        trial     = '0;
        qbit      = 1'b0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            trial = {step_rem[COUNT_W-2:0], step_word[DW-1]};
            qbit  = (trial >= i_divisor);
            if (qbit) begin
                trial = trial - i_divisor;
            end
            step_rem  = trial;
            step_word = {step_word[DW-2:0], qbit};
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_word = r_word;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(STEPS);
            n_word = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_word = step_word;
            n_rem  = step_rem;
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_word <= n_word;
        r_rem  <= n_rem;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_word;
    assign o_remainder = r_rem;

endmodule

@@ rtl/signed_integer_to_base_digits.sv @@
// Prints a signed VALUE_WIDTH-bit number as a string of symbol bytes in a base of
// 2 to MAX_SYMBOLS, taken from the symbol table and count registers. A negative
// number starts with '-'; digits follow most significant first and the final
// beat carries o_last. An invalid base (count out of range, or a used symbol that
// is NUL, '+', '-' or repeated) yields no beats. The input is held off from accept
// until the last character has been loaded into the output register. Per item,
// the value is accepted, then the base check walks through the used symbols in
// turn (stopping at once when the count is out of range), then each digit takes
// one pass through the shared divider, which retires 8 quotient bits per cycle,
// then the characters are loaded in order while the output side is ready.
module signed_integer_to_base_digits
    import sibd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_char_code,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DW   = ((VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int DGW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int NDW  = $clog2(VALUE_WIDTH + 1);
    localparam int IDXW = $clog2(VALUE_WIDTH);

    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;
    logic [COUNT_W-1:0]    r_sym_count;
    t_sym_tab              sym_tab;

    t_state                r_state, n_state;
    logic [DW-1:0]         r_mag;
    logic                  r_neg;
    logic [NDW-1:0]        r_nd;
    logic [DGW-1:0]        r_digits [VALUE_WIDTH];

    logic                  r_out_valid;
    logic [SYM_W-1:0]      r_char;
    logic                  r_last;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag_abs;
    t_chk_status            chk_st;
    logic                   div_done;
    logic [DW-1:0]          div_quot;
    logic [COUNT_W-1:0]     div_rem;
    logic [DW-1:0]          div_dividend;
    logic                   quot_zero;
    logic                   out_free;
    logic [NDW-1:0]         nd_dec;
    logic [DGW-1:0]         rd_digit;

    logic                   in_ready;
    logic                   chk_start;
    logic                   div_start;
    logic                   digit_we;
    logic                   out_load;
    logic [SYM_W-1:0]       out_char;
    logic                   out_last;

    assign sym_tab   = {r_sym_high, r_sym_low};
    assign raw       = i_value[VALUE_WIDTH-1:0];
    assign mag_abs   = raw[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - raw) : raw;
    assign quot_zero = (div_quot == '0);
    assign out_free  = !r_out_valid || i_out_ready;
    assign nd_dec    = r_nd - NDW'(1);
    assign rd_digit  = r_digits[nd_dec[IDXW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low   <= '0;
            r_sym_high  <= '0;
            r_sym_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SYMBOLS_LOW:  r_sym_low   <= i_cfg_data;
                REG_SYMBOLS_HIGH: r_sym_high  <= i_cfg_data;
                REG_SYMBOL_COUNT: r_sym_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    sibd_base_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (chk_start),
        .i_sym_tab (sym_tab),
        .i_count   (r_sym_count),
        .o_status  (chk_st)
    );

    sibd_divider #(
        .DW (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_sym_count),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (chk_st.done) n_state = chk_st.ok ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                if (div_done && quot_zero) n_state = r_neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (out_free) n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (out_free && (r_nd == NDW'(1))) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready     = 1'b0;
        chk_start    = 1'b0;
        div_start    = 1'b0;
        digit_we     = 1'b0;
        out_load     = 1'b0;
        out_char     = sym_tab[SYM_IDX_W'(rd_digit)];
        out_last     = (r_nd == NDW'(1));
        div_dividend = div_quot;
        unique case (r_state)
            ST_IDLE: begin
                in_ready  = 1'b1;
                chk_start = i_in_valid;
            end
            ST_CHECK: begin
                div_dividend = r_mag;
                div_start    = chk_st.done && chk_st.ok;
            end
            ST_DIVIDE: begin
                digit_we  = div_done;
                div_start = div_done && !quot_zero;
            end
            ST_SIGN: begin
                out_load = out_free;
                out_char = CH_MINUS;
                out_last = 1'b0;
            end
            ST_DIGITS: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (chk_start) begin
                r_nd <= '0;
            end else if (digit_we) begin
                r_nd <= r_nd + NDW'(1);
            end else if (out_load && (r_state == ST_DIGITS)) begin
                r_nd <= nd_dec;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (chk_start) begin
            r_mag <= DW'(mag_abs);
            r_neg <= raw[VALUE_WIDTH-1];
        end
        if (digit_we) begin
            r_digits[r_nd[IDXW-1:0]] <= div_rem[DGW-1:0];
        end
        if (out_load) begin
            r_char <= out_char;
            r_last <= out_last;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

`ifndef SYNTH
    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= NDW'(VALUE_WIDTH))
        else $error("digit count exceeds value width");

    a_digits_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGITS) |-> (r_nd != '0))
        else $error("emitting digits with an empty digit store");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    a_chk_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_st.done |-> (r_state == ST_CHECK))
        else $error("base check finished outside the check phase");

    a_text_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == ST_DIGITS))
        else $error("non-final character pending while text is not in progress");
`endif

endmodule

@@ dv/signed_integer_to_base_digits_test.sv @@
module signed_integer_to_base_digits_test;
    import sibd_pkg::*;

    localparam int MAX_SYMBOLS   = 16;
    localparam int VALUE_WIDTH   = 32;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 270;

    // Index 3 has no register behind it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [SYM_W-1:0] char_code;
        logic             last;
    } t_char_beat;

    class text_scoreboard;
        t_sym_tab         symbols;
        logic [COUNT_W-1:0] count;
        t_char_beat       pending_chars[$];
        int               errors;

        function new();
            symbols = '0;
            count   = '0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_SYMBOLS_LOW:  symbols[7:0]  = data;
                REG_SYMBOLS_HIGH: symbols[15:8] = data;
                REG_SYMBOL_COUNT: count         = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit base_usable();
            int i;
            int j;
            if (count < 2 || count > MAX_SYMBOLS)
                return 1'b0;
            for (i = 0; i < count; i++) begin
                if (symbols[i] == CH_NUL || symbols[i] == CH_PLUS || symbols[i] == CH_MINUS)
                    return 1'b0;
                for (j = i + 1; j < count; j++)
                    if (symbols[j] == symbols[i])
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        // Queue the text that one accepted value must produce.
        function void note_value(logic signed [VALUE_WIDTH-1:0] value);
            logic [VALUE_WIDTH-1:0] mag;
            logic [SYM_W-1:0]       digit_syms[$];
            t_char_beat             beat;
            int                     i;
            if (!base_usable())
                return;
            mag = value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - $unsigned(value)) : $unsigned(value);
            do begin
                digit_syms.push_front(symbols[mag % count]);
                mag = mag / count;
            end while (mag != 0);
            if (value[VALUE_WIDTH-1]) begin
                beat.char_code = CH_MINUS;
                beat.last      = 1'b0;
                pending_chars.push_back(beat);
            end
            for (i = 0; i < digit_syms.size(); i++) begin
                beat.char_code = digit_syms[i];
                beat.last      = (i == digit_syms.size() - 1);
                pending_chars.push_back(beat);
            end
        endfunction

        function void check_beat(logic [SYM_W-1:0] char_code, logic last);
            t_char_beat exp_beat;
            if (pending_chars.size() == 0) begin
                $error("unexpected beat: char_code=%h last=%b", char_code, last);
                errors++;
                return;
            end
            exp_beat = pending_chars.pop_front();
            if (char_code !== exp_beat.char_code) begin
                $error("char_code mismatch: expected %h, actual %h",
                       exp_beat.char_code, char_code);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $error("last mismatch: expected %b, actual %b", exp_beat.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [VALUE_WIDTH-1:0] in_value;
    logic                         out_valid;
    logic                         out_ready;
    logic [SYM_W-1:0]             out_char;
    logic                         out_last;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    text_scoreboard sb;
    int             gap_pct;
    int             stall_pct;

    signed_integer_to_base_digits #(
        .MAX_SYMBOLS(MAX_SYMBOLS),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_char_code (out_char),
        .o_last      (out_last),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_char, out_last);
    end

    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_value(v);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(index, data);
    endtask

    // Let the block go idle, then load a full symbol setting.
    task automatic apply_table(input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input logic [CFG_DATA_W-1:0] cnt);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_SYMBOLS_LOW, lo);
        write_reg(REG_SYMBOLS_HIGH, hi);
        write_reg(REG_SYMBOL_COUNT, cnt);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 77; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 77; end
            default: begin gap_pct = 35; stall_pct = 35; end
        endcase
    endtask

    function automatic t_sym_tab random_table(int cnt);
        t_sym_tab         tab;
        logic [SYM_W-1:0] b;
        bit               clash;
        int               i;
        int               j;
        tab = '0;
        for (i = 0; i < SYM_SLOTS; i++) begin
            if (i < cnt) begin
                do begin
                    b     = SYM_W'($urandom_range(1, 255));
                    clash = (b == CH_PLUS || b == CH_MINUS);
                    for (j = 0; j < i; j++)
                        if (tab[j] == b)
                            clash = 1'b1;
                end while (clash);
            end else begin
                b = SYM_W'($urandom_range(0, 255));
            end
            tab[i] = b;
        end
        return tab;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        logic signed [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom;
            2: begin
                v = $urandom_range(0, 99);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3: v = $signed($urandom) >>> $urandom_range(0, 31);
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh8000_0001;
                    3: v = 0;
                    4: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        t_sym_tab         tab;
        int               cnt;
        int               n;
        int               k;
        int               i;
        int               j;
        int               phase;
        int               valid_items;
        bit               usable;
        logic [COUNT_W-1:0] cnt_field;
        logic [CFG_DATA_W-1:0] junk;

        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_value  = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        set_idling(3);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset state has no usable base.
        send_value(7);

        // Decimal; unused high slots hold forbidden bytes, count carries junk above bit 4.
        apply_table(64'h3736_3534_3332_3130, 64'h2B2D_002D_2B00_3938,
                    64'hFFFF_FFFF_FFFF_FFEA);
        write_reg(REG_UNUSED, 64'h1);
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(1234567890);

        apply_table(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 64'd16);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(32'shDEAD_BEEF);
        send_value(15);
        send_value(16);

        apply_table(64'h0000_0000_0000_FF80, 64'h0, 64'd2);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(0);
        send_value(-1);

        // Broken bases: none of these may produce a beat.
        apply_table(64'h3736_3534_3332_3130, 64'h0, 64'd1);
        send_value(5);
        apply_table(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 64'd17);
        send_value(-5);
        apply_table(64'h0000_0000_0032_2B30, 64'h0, 64'd3);
        send_value(12);
        apply_table(64'h0000_0000_002D_3130, 64'h0, 64'd3);
        send_value(-12);
        apply_table(64'h3736_3534_3332_3130, 64'h6665_6463_6200_3938, 64'd12);
        send_value(100);
        apply_table(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3237, 64'd16);
        send_value(-100);

        phase       = 0;
        valid_items = 0;
        while (valid_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: cnt = 2;
                1: cnt = MAX_SYMBOLS;
                default: cnt = $urandom_range(2, MAX_SYMBOLS);
            endcase
            tab       = random_table(cnt);
            cnt_field = COUNT_W'(cnt);
            usable    = 1'b1;
            if ($urandom_range(99) < 15) begin
                usable = 1'b0;
                i = $urandom_range(0, cnt - 1);
                case ($urandom_range(0, 4))
                    0: tab[i] = CH_NUL;
                    1: tab[i] = CH_PLUS;
                    2: tab[i] = CH_MINUS;
                    3: begin
                        j = (i + $urandom_range(1, cnt - 1)) % cnt;
                        tab[i] = tab[j];
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0: cnt_field = COUNT_W'(0);
                            1: cnt_field = COUNT_W'(1);
                            default: cnt_field = COUNT_W'($urandom_range(MAX_SYMBOLS + 1, 31));
                        endcase
                    end
                endcase
            end
            set_idling(phase % 4);
            junk = {$urandom, $urandom};
            apply_table(tab[7:0], tab[15:8], {junk[CFG_DATA_W-1:COUNT_W], cnt_field});
            n = usable ? $urandom_range(20, 40) : 4;
            for (k = 0; k < n; k++) begin
                send_value(random_value());
                if (usable)
                    valid_items++;
                // Hold the sender off until all text is out.
                if (phase % 4 == 0 && k == n / 2)
                    hold_until_drained();
            end
            phase++;
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sibd_pkg.sv
rtl/sibd_base_check.sv
rtl/sibd_divider.sv
rtl/signed_integer_to_base_digits.sv
dv/signed_integer_to_base_digits_test.sv
